/* hw/rtl/tad_pkg.sv */
// tad_pkg: types and constants shared by the tar deframer modules.
// No dependencies.
`timescale 1ns / 1ps

package tad_pkg;

	localparam int unsigned BLOCK_BYTES = 512;
	localparam int unsigned OFS_W       = $clog2(BLOCK_BYTES);

	localparam logic [OFS_W-1:0] OFS_SIZE  = OFS_W'(124);
	localparam logic [OFS_W-1:0] OFS_SIZE_END = OFS_W'(136);
	localparam logic [OFS_W-1:0] OFS_TYPE  = OFS_W'(156);
	localparam logic [OFS_W-1:0] OFS_MAGIC = OFS_W'(257);
	localparam logic [OFS_W-1:0] OFS_MAGIC_END = OFS_W'(265);
	localparam logic [OFS_W-1:0] OFS_LAST  = OFS_W'(BLOCK_BYTES - 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;

	localparam int unsigned SIZE_W  = 36;
	localparam int unsigned ENTRY_W = 16;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_SKIP,
		PH_DEAD
	} phase_t;

	typedef enum logic [1:0] {
		SZ_PARSING,
		SZ_ENDED,
		SZ_BAD
	} size_status_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_HEADER,
		KIND_DONE,
		KIND_BAD_MAGIC
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [7:0]          payload_byte;
		logic                last_of_file;
		logic [ENTRY_W-1:0]  entry_number;
		logic [7:0]          entry_type;
		logic [SIZE_W-1:0]   entry_size;
		logic                archive_valid;
	} result_t;

	// per-byte output of the parser: an entry result and an end-of-archive result
	typedef struct packed {
		logic    main_vld;
		result_t main;
		logic    done_vld;
		result_t done;
	} step_out_t;

	// expected magic "ustar  " followed by NUL
	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h75;
			3'd1:    ch = 8'h73;
			3'd2:    ch = 8'h74;
			3'd3:    ch = 8'h61;
			3'd4:    ch = 8'h72;
			3'd5:    ch = CH_SPACE;
			3'd6:    ch = CH_SPACE;
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

endpackage

/* hw/rtl/tar_archive_deframer.sv */
// tar_archive_deframer: top level of the ustar archive deframer.
// Depends on tad_pkg, tad_parser and tad_result_fifo.
//
// Usage:
//   s_axis: one archive byte per word. tdata[7:0] is the byte, tlast marks the
//   final byte of the archive (ends it and emits an archive-done word).
//   m_axis: result words. tuser[1:0] is the kind (data, header summary,
//   archive done, bad magic), tlast flags the last content byte of a file,
//   tdata carries the remaining fields (see port comment).
// Path: an accepted byte is held in the input stage register, parsed there
//   combinationally and written to the result queue when it advances.
// Throughput: one byte per cycle while the queue has room; the parser state
//   update is a single pass through one 36-bit shift/decrement per byte. A byte
//   gives at most two result words (entry result plus archive done).
// Stall: results wait in a small register queue of 2**FIFO_AW words; the
//   input stage stalls once fewer than two free slots remain, so a stalled
//   receiver backs up to s_axis_tready without losing words.
// Reset: arst_n clears the parser to the start of an archive and empties the
//   queue; no clearing pass is needed.
`timescale 1ns / 1ps

module tar_archive_deframer #(
	parameter int unsigned FIFO_AW = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,   // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // payload_byte, entry_number, entry_type,
	                                    // entry_size, archive_valid, 3 zero bits
	output logic        m_axis_tlast,   // last_of_file
	output logic [1:0]  m_axis_tuser    // kind
);
	import tad_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        room2;
	logic        advance;
	step_out_t   step_out;
	logic [1:0]  push_cnt;
	result_t     push_a;
	result_t     out_word;

	assign advance       = valid_s1 && room2;
	assign s_axis_tready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	tad_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.data_byte    (byte_s1),
		.end_of_input (last_s1),
		.step_out     (step_out)
	);

	// entry result goes first; archive done follows it in the same cycle
	always_comb begin
		push_cnt = '0;
		if (advance)
			push_cnt = {1'b0, step_out.main_vld} + {1'b0, step_out.done_vld};
		push_a = step_out.main_vld ? step_out.main : step_out.done;
	end

	tad_result_fifo #(
		.AW (FIFO_AW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push_a   (push_a),
		.push_b   (step_out.done),
		.room2    (room2),
		.out_vld  (m_axis_tvalid),
		.out_rdy  (m_axis_tready),
		.out_word (out_word)
	);

	assign m_axis_tuser = out_word.kind;
	assign m_axis_tlast = out_word.last_of_file;
	assign m_axis_tdata = {3'b000, out_word.archive_valid, out_word.entry_size,
	                       out_word.entry_type, out_word.entry_number,
	                       out_word.payload_byte};

	// the parser only steps on a held byte
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1)
		else $error("tar_archive_deframer: step without byte");

	// a held byte that cannot advance stays in the input stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room2) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("tar_archive_deframer: input stage lost a byte");

endmodule

/* hw/rtl/tad_parser.sv */
// tad_parser: per-byte header/data state machine of the tar deframer.
// Depends on tad_pkg.
`timescale 1ns / 1ps

module tad_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        data_byte,
	input  logic              end_of_input,
	output tad_pkg::step_out_t step_out
);
	import tad_pkg::*;

	logic [OFS_W-1:0]   offset_q, offset_d;
	phase_t             phase_q, phase_d;
	logic               nfz_q, nfz_d;
	logic               sfz_q, sfz_d;
	logic [7:0]         type_q, type_d;
	logic               magic_ok_q, magic_ok_d;
	logic [SIZE_W-1:0]  acc_q, acc_d;
	size_status_t       sst_q, sst_d;
	logic [SIZE_W-1:0]  remain_q, remain_d;
	logic [ENTRY_W-1:0] entry_q, entry_d;

	logic [7:0]         typ_norm;
	logic [SIZE_W-1:0]  size_eff;
	logic [OFS_W-1:0]   magic_idx;

	always_comb begin
		offset_d   = offset_q;
		phase_d    = phase_q;
		nfz_d      = nfz_q;
		sfz_d      = sfz_q;
		type_d     = type_q;
		magic_ok_d = magic_ok_q;
		acc_d      = acc_q;
		sst_d      = sst_q;
		remain_d   = remain_q;
		entry_d    = entry_q;
		step_out   = '0;
		typ_norm   = '0;
		size_eff   = '0;
		magic_idx  = offset_q - OFS_MAGIC;

		case (phase_q)
			PH_HEADER: begin
				if (offset_q == '0) begin
					sfz_d      = 1'b0;
					type_d     = '0;
					magic_ok_d = 1'b1;
					acc_d      = '0;
					sst_d      = SZ_PARSING;
					nfz_d      = (data_byte == CH_NUL);
				end
				if (offset_q == OFS_SIZE)
					sfz_d = (data_byte == CH_NUL);
				if (offset_q >= OFS_SIZE && offset_q < OFS_SIZE_END && sst_d == SZ_PARSING) begin
					if (data_byte == CH_NUL)
						sst_d = SZ_ENDED;
					else if (data_byte inside {[CH_ZERO:CH_SEVEN]})
						acc_d = {acc_d[SIZE_W-4:0], data_byte[2:0]};
					else if (data_byte != CH_SPACE)
						sst_d = SZ_BAD;
				end
				if (offset_q == OFS_TYPE)
					type_d = data_byte;
				if (offset_q >= OFS_MAGIC && offset_q < OFS_MAGIC_END &&
				    data_byte != magic_byte(magic_idx[2:0]))
					magic_ok_d = 1'b0;
				if (offset_q == OFS_LAST) begin
					typ_norm = (type_d == CH_NUL) ? CH_ZERO : type_d;
					size_eff = (sst_d == SZ_BAD) ? '0 : acc_d;
					if (nfz_d && sfz_d && type_d == CH_NUL) begin
						// empty header block: nothing reported
					end else if (!magic_ok_d) begin
						step_out.main_vld          = 1'b1;
						step_out.main.kind         = KIND_BAD_MAGIC;
						step_out.main.entry_number = entry_q;
						phase_d                    = PH_DEAD;
					end else begin
						step_out.main_vld          = 1'b1;
						step_out.main.kind         = KIND_HEADER;
						step_out.main.entry_number = entry_q;
						step_out.main.entry_type   = typ_norm;
						step_out.main.entry_size   = size_eff;
						entry_d                    = entry_q + 1'b1;
						remain_d                   = size_eff;
						if (size_eff != '0)
							phase_d = (typ_norm == CH_ZERO) ? PH_DATA : PH_SKIP;
					end
				end
				offset_d = offset_q + 1'b1;
			end
			PH_DATA, PH_SKIP: begin
				if (remain_q != '0) begin
					remain_d = remain_q - 1'b1;
					if (phase_q == PH_DATA) begin
						step_out.main_vld          = 1'b1;
						step_out.main.kind         = KIND_DATA;
						step_out.main.payload_byte = data_byte;
						step_out.main.last_of_file = (remain_d == '0);
						step_out.main.entry_number = entry_q - 1'b1;
					end
				end
				if (offset_q == OFS_LAST && remain_d == '0)
					phase_d = PH_HEADER;
				offset_d = offset_q + 1'b1;
			end
			default: begin
				// dead after a magic error: bytes are dropped
			end
		endcase

		if (end_of_input) begin
			step_out.done_vld           = 1'b1;
			step_out.done.kind          = KIND_DONE;
			step_out.done.entry_number  = entry_d;
			step_out.done.archive_valid = (phase_d != PH_DEAD);
			offset_d   = '0;
			phase_d    = PH_HEADER;
			nfz_d      = 1'b0;
			sfz_d      = 1'b0;
			type_d     = '0;
			magic_ok_d = 1'b1;
			acc_d      = '0;
			sst_d      = SZ_PARSING;
			remain_d   = '0;
			entry_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			phase_q    <= PH_HEADER;
			nfz_q      <= 1'b0;
			sfz_q      <= 1'b0;
			type_q     <= '0;
			magic_ok_q <= 1'b1;
			acc_q      <= '0;
			sst_q      <= SZ_PARSING;
			remain_q   <= '0;
			entry_q    <= '0;
		end else if (step_en) begin
			offset_q   <= offset_d;
			phase_q    <= phase_d;
			nfz_q      <= nfz_d;
			sfz_q      <= sfz_d;
			type_q     <= type_d;
			magic_ok_q <= magic_ok_d;
			acc_q      <= acc_d;
			sst_q      <= sst_d;
			remain_q   <= remain_d;
			entry_q    <= entry_d;
		end
	end

	// once dead, only the end-of-archive word may come out
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DEAD) |-> !step_out.main_vld)
		else $error("tad_parser: entry result while dead");

	// entering the data phase from a header always loads a nonzero byte count
	assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && phase_q == PH_HEADER && phase_d == PH_DATA && !end_of_input)
		|-> (remain_d != '0))
		else $error("tad_parser: data phase entered with zero size");

	// a dead parser leaves only through end of input
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DEAD && !(step_en && end_of_input)) |=> (phase_q == PH_DEAD))
		else $error("tad_parser: left dead phase without end of input");

endmodule

/* hw/rtl/tad_result_fifo.sv */
// tad_result_fifo: small register queue for result words, up to two pushes a cycle.
// Depends on tad_pkg.
`timescale 1ns / 1ps

module tad_result_fifo #(
	parameter int unsigned AW = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  tad_pkg::result_t  push_a,
	input  tad_pkg::result_t  push_b,
	output logic              room2,
	output logic              out_vld,
	input  logic              out_rdy,
	output tad_pkg::result_t  out_word
);
	import tad_pkg::*;

	localparam int unsigned DEPTH = 1 << AW;

	result_t        mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [AW:0]    count_q;
	logic           pop;
	logic [AW-1:0]  wr_ptr_b;

	assign pop      = out_vld && out_rdy;
	assign out_vld  = (count_q != '0);
	assign out_word = mem_q[rd_ptr_q];
	assign room2    = (count_q <= (AW+1)'(DEPTH - 2));
	assign wr_ptr_b = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push_a;
		if (push_cnt == 2'd2)
			mem_q[wr_ptr_b] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(push_cnt) - (AW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("tad_result_fifo: count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> room2)
		else $error("tad_result_fifo: push without room");

endmodule
